@@ hdl/decimal_mantissa_to_text_core_macros.svh @@
// ----------------------------------------------------------------------------
// decimal_mantissa_to_text_core assertion macros
// shared property wrappers for the formatter's checks
// ----------------------------------------------------------------------------
`ifndef DECIMAL_MANTISSA_TO_TEXT_CORE_MACROS_SVH
`define DECIMAL_MANTISSA_TO_TEXT_CORE_MACROS_SVH

// checked only outside reset
`define DMT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define DMT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/dmt_pkg.sv @@
// ----------------------------------------------------------------------------
// dmt_pkg
// types, constants and text tables of the decimal mantissa formatter
// ----------------------------------------------------------------------------
package dmt_pkg;

   localparam int InputBits  = 96;
   localparam int ScaleW     = 5;
   localparam int KindW      = 2;
   localparam int CharW      = 7;
   localparam int PosW       = 5;
   localparam int MaxScale   = 28;
   localparam int MaxResults = 31;

   localparam logic [CharW-1:0] CharZero  = 7'h30;
   localparam logic [CharW-1:0] CharPoint = 7'h2e;
   localparam logic [CharW-1:0] CharMinus = 7'h2d;

   localparam int LenInf    = 8;
   localparam int LenNegInf = 17;
   localparam int LenNan    = 3;

   localparam logic [8*LenInf-1:0]    WordInf    = "INFINITY";
   localparam logic [8*LenNegInf-1:0] WordNegInf = {"NEGATIVE_", WordInf};
   localparam logic [8*LenNan-1:0]    WordNan    = "NAN";

   typedef enum logic [KindW-1:0] {
      KIND_NORMAL  = 2'd0,
      KIND_INF     = 2'd1,
      KIND_NEG_INF = 2'd2,
      KIND_NAN     = 2'd3
   } kind_type;

   typedef struct packed {
      logic [InputBits-1:0] mantissa;
      logic                 negative;
      logic [ScaleW-1:0]    scale;
      kind_type             kind;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [PosW-1:0] word_len(input kind_type kind);
      logic [PosW-1:0] len;
      case (kind)
         KIND_INF:     len = PosW'(LenInf);
         KIND_NEG_INF: len = PosW'(LenNegInf);
         KIND_NAN:     len = PosW'(LenNan);
         default:      len = PosW'(1);
      endcase
      return len;
   endfunction

   function automatic logic [CharW-1:0] word_char(input kind_type kind,
                                                   input logic [PosW-1:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (kind)
         KIND_INF: begin
            if (int'(idx) < LenInf) c = WordInf[8*(LenInf-1-int'(idx)) +: 8];
         end
         KIND_NEG_INF: begin
            if (int'(idx) < LenNegInf) c = WordNegInf[8*(LenNegInf-1-int'(idx)) +: 8];
         end
         KIND_NAN: begin
            if (int'(idx) < LenNan) c = WordNan[8*(LenNan-1-int'(idx)) +: 8];
         end
         default: c = 8'h00;
      endcase
      return c[CharW-1:0];
   endfunction

endpackage

@@ hdl/dmt_front.sv @@
// ----------------------------------------------------------------------------
// dmt_front
// accepts request transfers, decodes kind and clamps the scale
// ----------------------------------------------------------------------------
module dmt_front
   import dmt_pkg::*;
(
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [103:0]     req_tdata,
   input  logic [1:0]       req_tuser,
   input  queue_status_type q_status,
   output logic             q_push,
   output item_type         q_item
);

   logic [ScaleW-1:0] raw_scale;

   assign raw_scale  = req_tdata[InputBits+ScaleW:InputBits+1];
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && !q_status.full;

   always_comb begin
      q_item.mantissa = req_tdata[InputBits-1:0];
      q_item.negative = req_tdata[InputBits];
      // scales beyond the supported range print as the largest one
      q_item.scale    = (raw_scale > ScaleW'(MaxScale)) ? ScaleW'(MaxScale) : raw_scale;
      case (req_tuser)
         2'd1:    q_item.kind = KIND_INF;
         2'd2:    q_item.kind = KIND_NEG_INF;
         2'd3:    q_item.kind = KIND_NAN;
         default: q_item.kind = KIND_NORMAL;
      endcase
   end

endmodule

@@ hdl/dmt_queue.sv @@
// ----------------------------------------------------------------------------
// dmt_queue
// two-entry queue of decoded items between front and back
// ----------------------------------------------------------------------------
module dmt_queue
   import dmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type status
);

   localparam int Depth = 2;

   item_type   entry_ff [Depth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'(Depth));
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      else if (do_pop && !do_push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

@@ hdl/dmt_back.sv @@
// ----------------------------------------------------------------------------
// dmt_back
// double-dabble conversion, leading-zero scan and character emission
// ----------------------------------------------------------------------------
module dmt_back
   import dmt_pkg::*;
#(
   parameter int MANTISSA_BITS = 96,
   parameter int MAX_DIGITS    = 29
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

`include "decimal_mantissa_to_text_core_macros.svh"

   localparam int NBits = (MANTISSA_BITS < InputBits) ? MANTISSA_BITS : InputBits;
   localparam int StepW = $clog2(NBits + 1);
   localparam int CntW  = $clog2(MAX_DIGITS + 1);
   localparam int DigW  = 4 * MAX_DIGITS;
   localparam int CmpW  = CntW + ScaleW;

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b0000000001,
      ST_CONVERT    = 10'b0000000010,
      ST_SCAN       = 10'b0000000100,
      ST_SIGN       = 10'b0000001000,
      ST_LEAD_ZERO  = 10'b0000010000,
      ST_LEAD_POINT = 10'b0000100000,
      ST_PAD        = 10'b0001000000,
      ST_DIGITS     = 10'b0010000000,
      ST_MID_POINT  = 10'b0100000000,
      ST_WORD       = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [NBits-1:0]  shift_ff, shift_in;
   logic [DigW-1:0]   digits_ff, digits_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [ScaleW-1:0] pad_ff, pad_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [PosW-1:0]   widx_ff, widx_in;
   logic              neg_ff, neg_in;
   logic [ScaleW-1:0] scale_ff, scale_in;
   kind_type          kind_ff, kind_in;
   logic              valid_ff, valid_in;
   logic [CharW-1:0]  char_ff, char_in;
   logic              last_ff, last_in;

   logic [DigW-1:0]   adjusted;
   logic [3:0]        top_digit;
   logic [CmpW-1:0]   scale_x, cnt_x, cnt_m1_x, pad_x;
   logic              lead_form;
   state_type         body_state;
   logic              slot_free;
   logic              emit_req, emit_final, emit, emit_last;
   logic [CharW-1:0]  emit_char;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         adjusted[4*d +: 4] = (digits_ff[4*d +: 4] >= 4'd5) ?
                              digits_ff[4*d +: 4] + 4'd3 : digits_ff[4*d +: 4];
      end
   end

   assign top_digit  = digits_ff[DigW-1 -: 4];
   assign scale_x    = {{CntW{1'b0}}, scale_ff};
   assign cnt_x      = {{ScaleW{1'b0}}, cnt_ff};
   assign cnt_m1_x   = cnt_x - CmpW'(1);
   assign pad_x      = scale_x - cnt_x;
   assign lead_form  = (scale_x >= cnt_x);
   assign body_state = lead_form ? ST_LEAD_ZERO : ST_DIGITS;
   assign slot_free  = !valid_ff || rsp_tready;
   assign q_pop      = (state_ff == ST_IDLE) && !q_status.empty;

   // character wanted by the current state
   always_comb begin
      emit_req   = 1'b0;
      emit_final = 1'b0;
      emit_char  = CharZero;
      case (state_ff)
         ST_SIGN: begin
            emit_req  = 1'b1;
            emit_char = CharMinus;
         end
         ST_LEAD_ZERO, ST_PAD: begin
            emit_req  = 1'b1;
            emit_char = CharZero;
         end
         ST_LEAD_POINT, ST_MID_POINT: begin
            emit_req  = 1'b1;
            emit_char = CharPoint;
         end
         ST_DIGITS: begin
            emit_req   = 1'b1;
            emit_char  = CharZero + {3'b000, top_digit};
            emit_final = (cnt_ff == CntW'(1));
         end
         ST_WORD: begin
            emit_req   = 1'b1;
            emit_char  = word_char(kind_ff, widx_ff);
            emit_final = (widx_ff == word_len(kind_ff) - PosW'(1));
         end
         default: emit_req = 1'b0;
      endcase
   end

   assign emit      = emit_req && slot_free;
   // text is cut at the result limit
   assign emit_last = emit_final || (pos_ff == PosW'(MaxResults - 1));

   always_comb begin
      state_in  = state_ff;
      shift_in  = shift_ff;
      digits_in = digits_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      pad_in    = pad_ff;
      pos_in    = pos_ff;
      widx_in   = widx_ff;
      neg_in    = neg_ff;
      scale_in  = scale_ff;
      kind_in   = kind_ff;
      valid_in  = rsp_tready ? 1'b0 : valid_ff;
      char_in   = char_ff;
      last_in   = last_ff;

      if (emit) begin
         valid_in = 1'b1;
         char_in  = emit_char;
         last_in  = emit_last;
         pos_in   = pos_ff + PosW'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               neg_in    = q_item.negative;
               scale_in  = q_item.scale;
               kind_in   = q_item.kind;
               shift_in  = q_item.mantissa[NBits-1:0];
               digits_in = '0;
               step_in   = StepW'(NBits);
               pos_in    = '0;
               widx_in   = '0;
               state_in  = (q_item.kind == KIND_NORMAL) ? ST_CONVERT : ST_WORD;
            end
         end
         ST_CONVERT: begin
            digits_in = {adjusted[DigW-2:0], shift_ff[NBits-1]};
            shift_in  = shift_ff << 1;
            step_in   = step_ff - StepW'(1);
            if (step_ff == StepW'(1)) begin
               cnt_in   = CntW'(MAX_DIGITS);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // drop leading zeros one digit a cycle, keep at least one digit
            if (top_digit == 4'd0 && cnt_ff > CntW'(1)) begin
               digits_in = {digits_ff[DigW-5:0], 4'h0};
               cnt_in    = cnt_ff - CntW'(1);
            end else begin
               state_in = neg_ff ? ST_SIGN : body_state;
            end
         end
         ST_SIGN: begin
            if (emit) state_in = body_state;
         end
         ST_LEAD_ZERO: begin
            if (emit) state_in = ST_LEAD_POINT;
         end
         ST_LEAD_POINT: begin
            if (emit) begin
               pad_in   = pad_x[ScaleW-1:0];
               state_in = (pad_x != '0) ? ST_PAD : ST_DIGITS;
            end
         end
         ST_PAD: begin
            if (emit) begin
               pad_in = pad_ff - ScaleW'(1);
               if (pad_ff == ScaleW'(1)) state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (emit) begin
               digits_in = {digits_ff[DigW-5:0], 4'h0};
               cnt_in    = cnt_ff - CntW'(1);
               if (scale_ff != '0 && cnt_m1_x == scale_x) state_in = ST_MID_POINT;
            end
         end
         ST_MID_POINT: begin
            if (emit) state_in = ST_DIGITS;
         end
         ST_WORD: begin
            if (emit) widx_in = widx_ff + PosW'(1);
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit && emit_last) state_in = ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      digits_ff <= digits_in;
      step_ff   <= step_in;
      cnt_ff    <= cnt_in;
      pad_ff    <= pad_in;
      pos_ff    <= pos_in;
      widx_ff   <= widx_in;
      neg_ff    <= neg_in;
      scale_ff  <= scale_in;
      kind_ff   <= kind_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, char_ff};
   assign rsp_tlast  = last_ff;

   `DMT_ASSERT(a_convert_steps_left, (state_ff == ST_CONVERT) |-> (step_ff != '0), "conversion ran out of steps")
   `DMT_ASSERT(a_digits_left, (state_ff == ST_DIGITS) |-> (cnt_ff != '0), "digit emission with no digit left")
   `DMT_ASSERT(a_pad_left, (state_ff == ST_PAD) |-> (pad_ff != '0), "padding with no zero left")
   `DMT_ASSERT(a_last_ends_text, (emit && emit_last) |=> (state_ff == ST_IDLE), "text did not end after its last character")
   `DMT_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !valid_ff), "reset did not clear the back end")

endmodule

@@ hdl/decimal_mantissa_to_text_core.sv @@
// ----------------------------------------------------------------------------
// decimal_mantissa_to_text_core
// formats a 96-bit binary mantissa with sign and decimal scale as ASCII text
// ----------------------------------------------------------------------------
// One request transfer carries a mantissa, sign, scale and value kind; the
// response stream returns the text one character per transfer, tlast on the
// final character. A normal value is converted by double-dabble over its
// low MANTISSA_BITS (at most 96) bits in the digit adjuster, stripped of
// leading zeros while the layout is picked, then emitted one character per
// cycle (at most 31) while the response side does not stall; special kinds
// skip conversion and emit their word. A two-entry queue holds accepted
// requests while the back end works, so requests keep flowing until that
// queue fills.
module decimal_mantissa_to_text_core
   import dmt_pkg::*;
#(
   parameter int MANTISSA_BITS = 96,
   parameter int MAX_DIGITS    = 29
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [63:0] mantissa_low, [95:64] mantissa_high, [96] negative,
   // [101:97] scale, [103:102] zero
   input  logic [103:0] req_tdata,
   // [1:0] value_kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [6:0] out_char, [7] zero
   output logic [7:0]   rsp_tdata,
   // last_char
   output logic         rsp_tlast
);

   queue_status_type q_status;
   item_type         push_item, head_item;
   logic             q_push, q_pop;

   dmt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   dmt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   dmt_back #(
      .MANTISSA_BITS (MANTISSA_BITS),
      .MAX_DIGITS    (MAX_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ test/tb_decimal_mantissa_to_text_core.sv @@
// ----------------------------------------------------------------------------
// tb_decimal_mantissa_to_text_core
// self-checking bench for the decimal mantissa to text formatter: a table of
// hand-picked values, then random values, each response character compared
// in order against text given by the table or predicted from the request
// ----------------------------------------------------------------------------
module tb_decimal_mantissa_to_text_core;
   import dmt_pkg::*;

   localparam int StallLimit = 4000;
   localparam int HoldCycles = 400;
   localparam int RandomCount = 140;

   typedef struct {
      logic [CharW-1:0] ch;
      logic             last;
   } text_char_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;
   logic         rsp_tlast;

   text_char_type text_due [$];
   item_type      table_items [$];
   string         table_text [$];

   bit idle_on;
   bit hold_request;
   bit hold_taken;
   int mismatch_count = 0;
   int values_sent;
   int specials_sent;
   int chars_checked = 0;
   int stall_cycles = 0;

   decimal_mantissa_to_text_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // word printed for the negative infinity kind
   function automatic string neg_inf_word();
      return $sformatf("NEGATIVE_%s", "INFINITY");
   endfunction

   function automatic void queue_line(input logic [CharW-1:0] line [$]);
      int n;
      n = (line.size() > MaxResults) ? MaxResults : line.size();
      for (int k = 0; k < n; k++) begin
         text_due.push_back('{ch: line[k], last: (k == n - 1)});
      end
   endfunction

   function automatic void queue_word(input string w);
      logic [CharW-1:0] line [$];
      byte b;
      for (int k = 0; k < w.len(); k++) begin
         b = w[k];
         line.push_back(b[CharW-1:0]);
      end
      queue_line(line);
   endfunction

   // expected text of one value, appended to text_due
   function automatic void predict_text(input item_type it);
      logic [InputBits-1:0] rest;
      logic [InputBits-1:0] rem;
      logic [3:0]           digs [32];
      logic [CharW-1:0]     line [$];
      int                   ndig;
      int                   sc;
      ndig = 0;
      sc = (int'(it.scale) > MaxScale) ? MaxScale : int'(it.scale);
      case (it.kind)
         KIND_INF:     queue_word("INFINITY");
         KIND_NEG_INF: queue_word(neg_inf_word());
         KIND_NAN:     queue_word("NAN");
         default: begin
            rest = it.mantissa;
            do begin
               rem = rest % 10;
               digs[ndig] = rem[3:0];
               rest = rest / 10;
               ndig++;
            end while (rest != 0);
            if (it.negative) line.push_back(CharMinus);
            if (sc >= ndig) begin
               line.push_back(CharZero);
               line.push_back(CharPoint);
               for (int k = ndig; k < sc; k++) line.push_back(CharZero);
               for (int k = ndig - 1; k >= 0; k--) begin
                  line.push_back(CharZero + {3'b000, digs[k]});
               end
            end else begin
               for (int k = ndig - 1; k >= 0; k--) begin
                  line.push_back(CharZero + {3'b000, digs[k]});
                  if (sc != 0 && k == sc) line.push_back(CharPoint);
               end
            end
            queue_line(line);
         end
      endcase
   endfunction

   function automatic void add_row(input logic [InputBits-1:0] mantissa, input logic negative,
                                   input int scale, input kind_type kind, input string text);
      item_type it;
      it.mantissa = mantissa;
      it.negative = negative;
      it.scale    = scale[ScaleW-1:0];
      it.kind     = kind;
      table_items.push_back(it);
      table_text.push_back(text);
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_value(input item_type it, input string text);
      while (idle_on && $urandom_range(0, 99) < 31) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, it.scale, it.negative, it.mantissa};
      req_tuser  = it.kind;
      do @(posedge clock); while (!req_tready);
      if (text.len() != 0) queue_word(text);
      else predict_text(it);
      values_sent++;
      if (it.kind != KIND_NORMAL) specials_sent++;
      @(negedge clock);
   endtask

   function automatic item_type random_value();
      item_type it;
      it.mantissa = {$urandom, $urandom, $urandom};
      // vary the digit count so short values meet large scales often
      it.mantissa = it.mantissa >> $urandom_range(0, 95);
      it.negative = 1'($urandom_range(0, 1));
      it.scale    = ScaleW'($urandom_range(0, 31));
      it.kind     = ($urandom_range(0, 99) < 75) ? KIND_NORMAL : kind_type'($urandom_range(1, 3));
      return it;
   endfunction

   // response side: random stalls plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready = 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         rsp_tready = idle_on ? ($urandom_range(0, 99) >= 31) : 1'b1;
      end
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (text_due.size() == 0) begin
            $error("unexpected character transfer: out_char %h last_char %b",
                   rsp_tdata[CharW-1:0], rsp_tlast);
            mismatch_count++;
         end else begin
            want = text_due.pop_front();
            chars_checked++;
            if (rsp_tdata[CharW-1:0] !== want.ch) begin
               $error("out_char: expected %h, got %h", want.ch, rsp_tdata[CharW-1:0]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_char: expected %b, got %b", want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
         $display("timeout: no transfer for %0d cycles", StallLimit);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      item_type it;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = KIND_NORMAL;
      reset          = 1'b1;
      idle_on        = 1'b1;
      hold_request   = 1'b0;
      values_sent    = 0;
      specials_sent  = 0;

      add_row(96'd0,         1'b0, 0,  KIND_NORMAL,  "0");
      add_row(96'd0,         1'b1, 0,  KIND_NORMAL,  "-0");
      add_row(96'd0,         1'b0, 5,  KIND_NORMAL,  "0.00000");
      add_row({96{1'b1}},    1'b0, 0,  KIND_NORMAL,  "79228162514264337593543950335");
      add_row({96{1'b1}},    1'b1, 28, KIND_NORMAL,  "");
      add_row({96{1'b1}},    1'b0, 31, KIND_NORMAL,  "");
      add_row(96'd1,         1'b1, 28, KIND_NORMAL,  "");
      add_row(96'd1,         1'b0, 29, KIND_NORMAL,  "");
      add_row(96'd5,         1'b0, 30, KIND_NORMAL,  "");
      add_row(96'd12345,     1'b0, 2,  KIND_NORMAL,  "123.45");
      add_row(96'd12345,     1'b0, 4,  KIND_NORMAL,  "1.2345");
      add_row(96'd12345,     1'b0, 5,  KIND_NORMAL,  "0.12345");
      add_row(96'd100,       1'b0, 1,  KIND_NORMAL,  "10.0");
      add_row(96'd10,        1'b1, 1,  KIND_NORMAL,  "-1.0");
      add_row(96'd1,         1'b0, 1,  KIND_NORMAL,  "0.1");
      add_row(96'd999,       1'b0, 3,  KIND_NORMAL,  "0.999");
      add_row({1'b1, 95'd0}, 1'b0, 7,  KIND_NORMAL,  "");
      add_row({32'd0, {64{1'b1}}}, 1'b1, 12, KIND_NORMAL, "");
      add_row({{32{1'b1}}, 64'd0}, 1'b0, 20, KIND_NORMAL, "");
      add_row({96{1'b1}},    1'b1, 31, KIND_INF,     "INFINITY");
      add_row(96'd0,         1'b0, 0,  KIND_INF,     "INFINITY");
      add_row(96'd77,        1'b1, 3,  KIND_NEG_INF, neg_inf_word());
      add_row({96{1'b1}},    1'b0, 28, KIND_NAN,     "NAN");

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < table_items.size(); r++) begin
         send_value(table_items[r], table_text[r]);
      end

      for (int i = 0; i < RandomCount; i++) begin
         idle_on = !(i >= 60 && i < 100);
         if (i == 20) hold_request = 1'b1;
         if (i == 110) begin
            // sender pause until the text of every value so far has come out
            req_tvalid = 1'b0;
            while (text_due.size() != 0) @(negedge clock);
         end
         it = random_value();
         send_value(it, "");
      end
      req_tvalid = 1'b0;
      idle_on    = 1'b1;

      while (text_due.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("formatted %0d values (%0d special kinds), %0d characters checked,",
               values_sent, specials_sent, chars_checked);
      $display("with random stalls, a long response hold-off and a drain pause");
      if (mismatch_count == 0 && text_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
